/* src/ipv4_receive_header_checker_macros.svh */
// Assertion macros shared by the modules that check their own behavior.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef IPV4_RECEIVE_HEADER_CHECKER_MACROS_SVH
`define IPV4_RECEIVE_HEADER_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV4RX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ipv4rx: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPV4RX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ipv4rx: next-cycle check failed");

`endif

/* src/ipv4rx_pkg.sv */
package ipv4rx_pkg;

    // Header field constants.
    localparam logic [3:0]  IpVersion4     = 4'd4;
    localparam logic [7:0]  ProtoIcmp      = 8'd1;
    localparam logic [7:0]  ProtoTcp       = 8'd6;
    localparam logic [7:0]  ProtoUdp       = 8'd17;
    localparam logic [15:0] MinPacketBytes = 16'd20;
    localparam logic [5:0]  MinHeaderBytes = 6'd20;
    localparam logic [6:0]  IcmpExtraBytes = 7'd8;
    localparam logic [15:0] CsumGood       = 16'hFFFF;
    localparam logic [15:0] CountMax       = 16'hFFFF;
    localparam logic [31:0] LimitedBcast   = 32'hFFFF_FFFF;

    // Configuration port.
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 32;
    localparam logic [2:0] ProtocolsEnabledReset = 3'b111;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_IFACE_ADDRESS  = 2'd0,
        CFG_SUBNET_MASK    = 2'd1,
        CFG_PROTOCOLS      = 2'd2
    } cfg_index_t;

    // Bit positions in protocols_enabled.
    localparam int EnIcmpBit = 0;
    localparam int EnTcpBit  = 1;
    localparam int EnUdpBit  = 2;

    typedef enum logic [3:0] {
        VERDICT_ICMP        = 4'd0,
        VERDICT_TCP         = 4'd1,
        VERDICT_UDP         = 4'd2,
        VERDICT_BAD_HEADER  = 4'd3,
        VERDICT_BAD_CSUM    = 4'd4,
        VERDICT_FRAG_UNSUPP = 4'd5,
        VERDICT_IGNORE      = 4'd6,
        VERDICT_UNKNOWN     = 4'd7,
        VERDICT_UNREACHABLE = 4'd8
    } verdict_t;

    typedef enum logic [1:0] {
        REPLY_NONE          = 2'd0,
        REPLY_HOST_UNREACH  = 2'd1,
        REPLY_PROTO_UNREACH = 2'd2
    } icmp_reply_t;

    // Queue between the byte parser and the verdict stage.
    localparam int QueueDepth    = 4;
    localparam int QueuePtrWidth = $clog2(QueueDepth);

    // Everything the verdict stage needs to know about one finished packet.
    typedef struct packed {
        logic [15:0] byte_total;
        logic [7:0]  ver_ihl;
        logic [15:0] checksum;
        logic [15:0] pkt_length;
        logic [15:0] frag_field;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] dest;
        logic        bcast;
    } pkt_summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Ones' complement 16-bit add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        logic [16:0] folded;
        sum    = {1'b0, a} + {1'b0, b};
        folded = {1'b0, sum[15:0]} + {16'd0, sum[16]};
        return folded[15:0];
    endfunction

endpackage

/* src/ipv4rx_parser.sv */
module ipv4rx_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic                   frame_broadcast,
    output logic                   push,
    output ipv4rx_pkg::pkt_summary_t summary
);
    import ipv4rx_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] checksum_reg, checksum_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [15:0] pkt_length_reg, pkt_length_next;
    logic [15:0] frag_field_reg, frag_field_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [31:0] source_reg, source_next;
    logic [31:0] dest_reg, dest_next;
    logic        bcast_reg, bcast_next;

    pkt_summary_t upd;
    logic [7:0]   high_byte_upd;
    logic [5:0]   hdr_lim;
    logic         in_header;

    // Fold the current word into the packet state.
    always_comb begin
        upd           = '{byte_total: byte_count_reg, ver_ihl: ver_ihl_reg,
                          checksum: checksum_reg, pkt_length: pkt_length_reg,
                          frag_field: frag_field_reg, protocol: protocol_reg,
                          source: source_reg, dest: dest_reg, bcast: bcast_reg};
        high_byte_upd = high_byte_reg;

        if (byte_count_reg == 16'd0) begin
            upd.ver_ihl = data_byte;
            upd.bcast   = frame_broadcast;
        end

        hdr_lim   = {upd.ver_ihl[3:0], 2'b00};
        in_header = byte_count_reg < {10'd0, hdr_lim};

        // Even header bytes are held, odd ones complete a 16-bit word.
        if (in_header) begin
            if (!byte_count_reg[0]) begin
                high_byte_upd = data_byte;
            end else begin
                upd.checksum = ones_add(checksum_reg, {high_byte_reg, data_byte});
            end
        end

        unique case (byte_count_reg)
            16'd2, 16'd3:   upd.pkt_length   = {pkt_length_reg[7:0], data_byte};
            16'd6, 16'd7:   upd.frag_field   = {frag_field_reg[7:0], data_byte};
            16'd9:          upd.protocol     = data_byte;
            16'd12, 16'd13,
            16'd14, 16'd15: upd.source       = {source_reg[23:0], data_byte};
            16'd16, 16'd17,
            16'd18, 16'd19: upd.dest         = {dest_reg[23:0], data_byte};
            default: ;
        endcase

        if (byte_count_reg != CountMax) begin
            upd.byte_total = byte_count_reg + 16'd1;
        end
    end

    // A last word hands the summary to the queue and clears the state.
    always_comb begin
        push              = accept && last_byte;
        summary           = upd;
        byte_count_next   = byte_count_reg;
        ver_ihl_next      = ver_ihl_reg;
        checksum_next     = checksum_reg;
        high_byte_next    = high_byte_reg;
        pkt_length_next   = pkt_length_reg;
        frag_field_next   = frag_field_reg;
        protocol_next     = protocol_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;
        bcast_next        = bcast_reg;
        if (accept) begin
            if (last_byte) begin
                byte_count_next   = '0;
                ver_ihl_next      = '0;
                checksum_next     = '0;
                high_byte_next    = '0;
                pkt_length_next   = '0;
                frag_field_next   = '0;
                protocol_next     = '0;
                source_next       = '0;
                dest_next         = '0;
                bcast_next        = 1'b0;
            end else begin
                byte_count_next   = upd.byte_total;
                ver_ihl_next      = upd.ver_ihl;
                checksum_next     = upd.checksum;
                high_byte_next    = high_byte_upd;
                pkt_length_next   = upd.pkt_length;
                frag_field_next   = upd.frag_field;
                protocol_next     = upd.protocol;
                source_next       = upd.source;
                dest_next         = upd.dest;
                bcast_next        = upd.bcast;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            ver_ihl_reg      <= '0;
            checksum_reg     <= '0;
            high_byte_reg    <= '0;
            pkt_length_reg   <= '0;
            frag_field_reg   <= '0;
            protocol_reg     <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
            bcast_reg        <= 1'b0;
        end else begin
            byte_count_reg   <= byte_count_next;
            ver_ihl_reg      <= ver_ihl_next;
            checksum_reg     <= checksum_next;
            high_byte_reg    <= high_byte_next;
            pkt_length_reg   <= pkt_length_next;
            frag_field_reg   <= frag_field_next;
            protocol_reg     <= protocol_next;
            source_reg       <= source_next;
            dest_reg         <= dest_next;
            bcast_reg        <= bcast_next;
        end
    end

endmodule

/* src/ipv4rx_queue.sv */
module ipv4rx_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  ipv4rx_pkg::pkt_summary_t  push_data,
    input  logic                      pop,
    output ipv4rx_pkg::pkt_summary_t  head_data,
    output ipv4rx_pkg::queue_status_t status
);
    import ipv4rx_pkg::*;

    pkt_summary_t              entries_reg [QueueDepth];
    logic [QueuePtrWidth-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrWidth-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrWidth:0]    count_reg, count_next;

    localparam logic [QueuePtrWidth:0] DepthCount = (QueuePtrWidth + 1)'(QueueDepth);
    localparam logic [QueuePtrWidth-1:0] LastSlot = QueuePtrWidth'(QueueDepth - 1);

    assign status.full  = count_reg == DepthCount;
    assign status.empty = count_reg == '0;
    assign head_data    = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update; callers never push when full or pop when empty.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Summary storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/ipv4rx_verdict.sv */
module ipv4rx_verdict (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ipv4rx_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [ipv4rx_pkg::CfgDataWidth-1:0]  cfg_wr_data,
    input  ipv4rx_pkg::pkt_summary_t             head_data,
    input  ipv4rx_pkg::queue_status_t            status,
    output logic                                 pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [3:0]                           m_verdict,
    output logic [5:0]                           m_header_bytes,
    output logic [7:0]                           m_protocol,
    output logic [31:0]                          m_source_address,
    output logic [31:0]                          m_dest_address,
    output logic [15:0]                          m_pad_bytes,
    output logic [1:0]                           m_icmp_reply,
    output logic [6:0]                           m_icmp_keep_bytes
);
    import ipv4rx_pkg::*;

    logic [31:0] iface_address_reg;
    logic [31:0] subnet_mask_reg;
    logic [2:0]  protocols_enabled_reg;

    logic        m_valid_reg, m_valid_next;
    verdict_t    verdict_reg, verdict_next;
    logic [5:0]  hdr_bytes_reg;
    logic [7:0]  protocol_reg;
    logic [31:0] source_reg;
    logic [31:0] dest_reg;
    logic [15:0] pad_reg, pad_next;
    icmp_reply_t reply_reg, reply_next;
    logic [6:0]  keep_reg, keep_next;

    logic [5:0]  hdr;
    logic [6:0]  keep_full;
    logic        is_frag;
    logic        header_bad;
    logic        length_bad;
    logic        may_reply;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iface_address_reg     <= '0;
            subnet_mask_reg       <= '0;
            protocols_enabled_reg <= ProtocolsEnabledReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IFACE_ADDRESS: iface_address_reg     <= cfg_wr_data;
                CFG_SUBNET_MASK:   subnet_mask_reg       <= cfg_wr_data;
                CFG_PROTOCOLS:     protocols_enabled_reg <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    // A summary moves into the output register whenever that register is free.
    assign pop          = !status.empty && (!m_valid_reg || m_ready);
    assign m_valid_next = pop || (m_valid_reg && !m_ready);

    // Classify the packet at the head of the queue.
    always_comb begin
        hdr        = {head_data.ver_ihl[3:0], 2'b00};
        keep_full  = {1'b0, hdr} + IcmpExtraBytes;
        is_frag    = head_data.frag_field[13] || (head_data.frag_field[12:0] != '0);
        header_bad = (head_data.byte_total < MinPacketBytes)
                  || (head_data.ver_ihl[7:4] != IpVersion4)
                  || (hdr < MinHeaderBytes)
                  || (head_data.byte_total < {10'd0, hdr});
        length_bad = (head_data.pkt_length > head_data.byte_total)
                  || (head_data.pkt_length < {10'd0, hdr});
        pad_next   = '0;
        reply_next = REPLY_NONE;
        keep_next  = '0;
        may_reply  = 1'b0;

        priority if (header_bad) begin
            verdict_next = VERDICT_BAD_HEADER;
        end else if (head_data.checksum != CsumGood) begin
            verdict_next = VERDICT_BAD_CSUM;
        end else if (length_bad) begin
            verdict_next = VERDICT_BAD_HEADER;
        end else begin
            pad_next = head_data.byte_total - head_data.pkt_length;
            if (is_frag) begin
                if (!head_data.bcast && iface_address_reg != '0
                        && head_data.dest == iface_address_reg) begin
                    verdict_next = VERDICT_FRAG_UNSUPP;
                end else begin
                    verdict_next = VERDICT_IGNORE;
                end
            end else begin
                priority if (head_data.protocol == ProtoIcmp
                        && protocols_enabled_reg[EnIcmpBit]) begin
                    verdict_next = VERDICT_ICMP;
                end else if (head_data.protocol == ProtoTcp
                        && protocols_enabled_reg[EnTcpBit]) begin
                    verdict_next = VERDICT_TCP;
                end else if (head_data.protocol == ProtoUdp
                        && protocols_enabled_reg[EnUdpBit]) begin
                    verdict_next = VERDICT_UDP;
                end else begin
                    verdict_next = (head_data.dest == iface_address_reg)
                                 ? VERDICT_UNKNOWN : VERDICT_UNREACHABLE;
                    may_reply = 1'b1;
                end
            end
        end

        // No ICMP error goes back for broadcasts of any kind.
        if (may_reply && !head_data.bcast
                && head_data.dest != (iface_address_reg | ~subnet_mask_reg)
                && head_data.dest != LimitedBcast) begin
            reply_next = (verdict_next == VERDICT_UNKNOWN)
                       ? REPLY_PROTO_UNREACH : REPLY_HOST_UNREACH;
            keep_next  = ({9'd0, keep_full} > head_data.pkt_length)
                       ? head_data.pkt_length[6:0] : keep_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            verdict_reg   <= verdict_next;
            hdr_bytes_reg <= hdr;
            protocol_reg  <= head_data.protocol;
            source_reg    <= head_data.source;
            dest_reg      <= head_data.dest;
            pad_reg       <= pad_next;
            reply_reg     <= reply_next;
            keep_reg      <= keep_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_verdict         = verdict_reg;
    assign m_header_bytes    = hdr_bytes_reg;
    assign m_protocol        = protocol_reg;
    assign m_source_address  = source_reg;
    assign m_dest_address    = dest_reg;
    assign m_pad_bytes       = pad_reg;
    assign m_icmp_reply      = reply_reg;
    assign m_icmp_keep_bytes = keep_reg;

endmodule

/* src/ipv4_receive_header_checker.sv */
// IPv4 receive header checker. Packet bytes enter one per clock on the s_ channel
// while s_ready is high, with a mark on the final byte, and bytes keep flowing
// while verdicts wait. A byte parser latches the header fields and sums the
// header words, then on the final byte it hands a summary to a four-entry queue.
// A verdict stage takes summaries from that queue and presents one result word
// per packet on the m_ channel; the summary is written into the queue and then
// into the output register. s_ready drops only when four summaries are queued
// behind the result held on the m_ channel, five verdicts in all still waiting
// to be taken. The user must write the interface address, subnet mask and
// enabled protocols through the cfg_ port only while no packet is in flight;
// the block itself does not enforce this.
`include "ipv4_receive_header_checker_macros.svh"

module ipv4_receive_header_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ipv4rx_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [ipv4rx_pkg::CfgDataWidth-1:0]  cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_last_byte,
    input  logic                                 s_frame_broadcast,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [3:0]                           m_verdict,
    output logic [5:0]                           m_header_bytes,
    output logic [7:0]                           m_protocol,
    output logic [31:0]                          m_source_address,
    output logic [31:0]                          m_dest_address,
    output logic [15:0]                          m_pad_bytes,
    output logic [1:0]                           m_icmp_reply,
    output logic [6:0]                           m_icmp_keep_bytes
);
    import ipv4rx_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    pkt_summary_t  push_data;
    pkt_summary_t  head_data;
    queue_status_t status;

    assign s_ready = !status.full;
    assign accept  = s_valid && s_ready;

    // Front: byte parser.
    ipv4rx_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_data_byte),
        .last_byte       (s_last_byte),
        .frame_broadcast (s_frame_broadcast),
        .push            (push),
        .summary         (push_data)
    );

    // Packet summaries waiting for a verdict.
    ipv4rx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (status)
    );

    // Back: verdict and result register.
    ipv4rx_verdict u_verdict (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .head_data         (head_data),
        .status            (status),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_header_bytes    (m_header_bytes),
        .m_protocol        (m_protocol),
        .m_source_address  (m_source_address),
        .m_dest_address    (m_dest_address),
        .m_pad_bytes       (m_pad_bytes),
        .m_icmp_reply      (m_icmp_reply),
        .m_icmp_keep_bytes (m_icmp_keep_bytes)
    );

    // A byte that is not the last one never produces a summary.
    `IPV4RX_ASSERT_SAME(a_push_only_on_last, accept && !s_last_byte, !push)
    // A pushed summary is waiting in the queue on the next cycle.
    `IPV4RX_ASSERT_NEXT(a_push_lands, push, !status.empty)
    // ICMP errors are only offered for unknown protocols or unreachable packets.
    `IPV4RX_ASSERT_SAME(a_reply_needs_verdict, m_valid && m_icmp_reply != REPLY_NONE,
        m_verdict == VERDICT_UNKNOWN || m_verdict == VERDICT_UNREACHABLE)
    // Rejected headers carry no padding.
    `IPV4RX_ASSERT_SAME(a_no_pad_when_bad,
        m_valid && (m_verdict == VERDICT_BAD_HEADER || m_verdict == VERDICT_BAD_CSUM),
        m_pad_bytes == 16'd0)

endmodule

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4rx_pkg::*;

    localparam int DrainCycles = 8;
    localparam int PhaseCount = 6;
    localparam int RandomBytesPerPhase = 150;
    localparam logic [31:0] HomeAddr = 32'hC0A8_010A;
    localparam logic [31:0] HomeMask = 32'hFFFF_FF00;
    localparam logic [31:0] HomeBcast = 32'hC0A8_01FF;
    localparam logic [31:0] RemoteHost = 32'h0808_0808;
    localparam logic [15:0] FlagDontFrag = 16'h4000;
    localparam logic [15:0] FlagMoreFrags = 16'h2000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       frame_bcast;
    } rx_word_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [5:0]  header_bytes;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] dest;
        logic [15:0] pad_bytes;
        icmp_reply_t reply;
        logic [6:0]  keep_bytes;
    } ipv4_verdict_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_LONG_STALLS
    } ready_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic s_last_byte = 1'b0;
    logic s_frame_broadcast = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_verdict;
    logic [5:0] m_header_bytes;
    logic [7:0] m_protocol;
    logic [31:0] m_source_address;
    logic [31:0] m_dest_address;
    logic [15:0] m_pad_bytes;
    logic [1:0] m_icmp_reply;
    logic [6:0] m_icmp_keep_bytes;

    // Words waiting to be sent, verdicts waiting to come back.
    rx_word_t rx_words[$];
    ipv4_verdict_t pending_verdicts[$];
    logic [7:0] pkt_bytes[$];

    // Shadow copy of the configuration registers.
    logic [31:0] cfg_addr = 32'd0;
    logic [31:0] cfg_mask = 32'd0;
    logic [2:0] cfg_protocols = ProtocolsEnabledReset;

    // Shadow copy of the per-packet parse state.
    logic [15:0] rx_count = '0;
    logic [7:0] rx_ver_ihl = '0;
    logic [15:0] rx_sum = '0;
    logic [7:0] rx_hi = '0;
    logic [15:0] rx_total_len = '0;
    logic [15:0] rx_frag = '0;
    logic [7:0] rx_proto = '0;
    logic [31:0] rx_src = '0;
    logic [31:0] rx_dst = '0;
    logic rx_bcast = 1'b0;

    int error_count = 0;
    int verdicts_checked = 0;
    int bytes_accepted = 0;
    int bytes_queued = 0;
    int verdict_hits[16];
    int burst_left = 0;
    int gap_left = 0;
    int mode_left = 0;
    int stall_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    rx_word_t next_word;
    ipv4_verdict_t head_verdict;

    ipv4_receive_header_checker u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .s_frame_broadcast (s_frame_broadcast),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_header_bytes    (m_header_bytes),
        .m_protocol        (m_protocol),
        .m_source_address  (m_source_address),
        .m_dest_address    (m_dest_address),
        .m_pad_bytes       (m_pad_bytes),
        .m_icmp_reply      (m_icmp_reply),
        .m_icmp_keep_bytes (m_icmp_keep_bytes)
    );

    always #1 aclk = ~aclk;

    // Ones' complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] ones_sum16(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = acc + w;
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Advances the header parse by one word and, on the last byte, works out the verdict.
    task automatic parse_rx_byte(input logic [7:0] b, input logic last, input logic fb);
        logic [15:0] pos;
        logic [6:0] hdr_len;
        ipv4_verdict_t r;
        pos = rx_count;
        if (pos == 16'd0) begin
            rx_ver_ihl = b;
            rx_bcast = fb;
        end
        hdr_len = {1'b0, rx_ver_ihl[3:0], 2'b00};
        if (pos < hdr_len) begin
            if (!pos[0]) begin
                rx_hi = b;
            end else begin
                rx_sum = ones_sum16(rx_sum, {rx_hi, b});
            end
        end
        case (pos)
            16'd2, 16'd3: rx_total_len = {rx_total_len[7:0], b};
            16'd6, 16'd7: rx_frag = {rx_frag[7:0], b};
            16'd9: rx_proto = b;
            16'd12, 16'd13, 16'd14, 16'd15: rx_src = {rx_src[23:0], b};
            16'd16, 16'd17, 16'd18, 16'd19: rx_dst = {rx_dst[23:0], b};
            default: ;
        endcase
        if (rx_count != CountMax) rx_count++;
        if (last) begin
            r.verdict = VERDICT_BAD_HEADER;
            r.header_bytes = hdr_len[5:0];
            r.protocol = rx_proto;
            r.source = rx_src;
            r.dest = rx_dst;
            r.pad_bytes = 16'd0;
            r.reply = REPLY_NONE;
            r.keep_bytes = 7'd0;
            if (rx_count < MinPacketBytes || rx_ver_ihl[7:4] != IpVersion4 ||
                hdr_len < MinHeaderBytes || rx_count < hdr_len) begin
                r.verdict = VERDICT_BAD_HEADER;
            end else if (rx_sum != CsumGood) begin
                r.verdict = VERDICT_BAD_CSUM;
            end else if (rx_total_len > rx_count || rx_total_len < hdr_len) begin
                r.verdict = VERDICT_BAD_HEADER;
            end else begin
                r.pad_bytes = rx_count - rx_total_len;
                if (rx_frag[13] || rx_frag[12:0] != 13'd0) begin
                    // Fragments are only claimed when addressed to us by unicast.
                    if (!rx_bcast && cfg_addr != 32'd0 && rx_dst == cfg_addr) begin
                        r.verdict = VERDICT_FRAG_UNSUPP;
                    end else begin
                        r.verdict = VERDICT_IGNORE;
                    end
                end else begin
                    if (rx_proto == ProtoIcmp && cfg_protocols[EnIcmpBit]) begin
                        r.verdict = VERDICT_ICMP;
                    end else if (rx_proto == ProtoTcp && cfg_protocols[EnTcpBit]) begin
                        r.verdict = VERDICT_TCP;
                    end else if (rx_proto == ProtoUdp && cfg_protocols[EnUdpBit]) begin
                        r.verdict = VERDICT_UDP;
                    end else if (rx_dst == cfg_addr) begin
                        r.verdict = VERDICT_UNKNOWN;
                    end else begin
                        r.verdict = VERDICT_UNREACHABLE;
                    end
                    // No ICMP error goes back for any kind of broadcast.
                    if ((r.verdict == VERDICT_UNKNOWN || r.verdict == VERDICT_UNREACHABLE) &&
                        !rx_bcast && rx_dst != (cfg_addr | ~cfg_mask) &&
                        rx_dst != LimitedBcast) begin
                        r.reply = (r.verdict == VERDICT_UNKNOWN) ? REPLY_PROTO_UNREACH
                                                                 : REPLY_HOST_UNREACH;
                        if (16'(hdr_len) + 16'(IcmpExtraBytes) > rx_total_len) begin
                            r.keep_bytes = rx_total_len[6:0];
                        end else begin
                            r.keep_bytes = hdr_len + IcmpExtraBytes;
                        end
                    end
                end
            end
            pending_verdicts.push_back(r);
            rx_count = '0;
            rx_ver_ihl = '0;
            rx_sum = '0;
            rx_hi = '0;
            rx_total_len = '0;
            rx_frag = '0;
            rx_proto = '0;
            rx_src = '0;
            rx_dst = '0;
            rx_bcast = 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Moves the scratch packet into the word queue; the broadcast flag counts only on
    // the first word, so the others carry noise.
    task automatic queue_packet(input logic frame_bcast);
        rx_word_t w;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            w.data_byte = pkt_bytes[i];
            w.last_byte = (i == pkt_bytes.size() - 1);
            w.frame_bcast = (i == 0) ? frame_bcast : 1'($urandom_range(0, 1));
            rx_words.push_back(w);
        end
        bytes_queued += pkt_bytes.size();
    endtask

    // Builds an IPv4 packet with a correct checksum unless told otherwise. len_adjust skews
    // the total length field, and a nonzero cut_len truncates the packet to that many bytes.
    task automatic build_ipv4(input int ihl, input logic [3:0] version, input int payload_len,
                              input int pad_len, input logic [15:0] frag,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input bit bad_csum,
                              input int len_adjust, input int cut_len,
                              input logic frame_bcast);
        int hdr;
        logic [15:0] tl;
        logic [15:0] csum;
        hdr = ihl * 4;
        tl = 16'(hdr + payload_len + len_adjust);
        pkt_bytes.delete();
        pkt_bytes.push_back({version, 4'(ihl)});
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(tl[15:8]);
        pkt_bytes.push_back(tl[7:0]);
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(frag[15:8]);
        pkt_bytes.push_back(frag[7:0]);
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(proto);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(8'd0);
        for (int k = 3; k >= 0; k--) pkt_bytes.push_back(src[8*k +: 8]);
        for (int k = 3; k >= 0; k--) pkt_bytes.push_back(dst[8*k +: 8]);
        for (int k = 20; k < hdr; k++) pkt_bytes.push_back(8'($urandom));
        csum = 16'd0;
        for (int k = 0; k + 1 < hdr; k += 2) begin
            csum = ones_sum16(csum, {pkt_bytes[k], pkt_bytes[k+1]});
        end
        csum = ~csum;
        if (bad_csum) csum ^= 16'($urandom_range(1, 65535));
        pkt_bytes[10] = csum[15:8];
        pkt_bytes[11] = csum[7:0];
        for (int k = 0; k < payload_len + pad_len; k++) pkt_bytes.push_back(8'($urandom));
        if (cut_len > 0) begin
            while (pkt_bytes.size() > cut_len) pkt_bytes.pop_back();
        end
        queue_packet(frame_bcast);
    endtask

    // Mostly well-formed packets with random content, the rest malformed or noise.
    task automatic queue_random_packet();
        int kind;
        int ihl;
        int payload;
        int pad;
        logic [15:0] frag;
        logic [7:0] proto;
        logic [31:0] dst;
        logic fb;
        kind = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(6, 15);
        payload = $urandom_range(0, 16);
        pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        fb = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: frag = ($urandom_range(0, 1) != 0) ? FlagDontFrag : 16'h0000;
            6: frag = FlagMoreFrags | 16'($urandom_range(0, 1) * FlagDontFrag);
            7: frag = 16'($urandom_range(1, 8191));
            default: frag = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: proto = ProtoIcmp;
            1: proto = ProtoTcp;
            2: proto = ProtoUdp;
            default: proto = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: dst = cfg_addr;
            1: dst = cfg_addr | ~cfg_mask;
            2: dst = LimitedBcast;
            3: dst = (cfg_addr & cfg_mask) | (32'($urandom) & ~cfg_mask);
            default: dst = 32'($urandom);
        endcase
        if (kind < 75) begin
            build_ipv4(ihl, IpVersion4, payload, pad, frag, proto, 32'($urandom), dst,
                       0, 0, 0, fb);
        end else begin
            case (kind % 8)
                0: build_ipv4(ihl, IpVersion4, payload, pad, frag, proto, 32'($urandom), dst,
                              1, 0, 0, fb);
                1: build_ipv4(ihl, 4'($urandom), payload, pad, frag, proto, 32'($urandom),
                              dst, 0, 0, 0, fb);
                2: build_ipv4($urandom_range(0, 4), IpVersion4, payload, pad, frag, proto,
                              32'($urandom), dst, 0, 0, 0, fb);
                3: build_ipv4(ihl, IpVersion4, payload, pad, frag, proto, 32'($urandom), dst,
                              0, pad + $urandom_range(1, 40), 0, fb);
                4: build_ipv4(ihl, IpVersion4, payload, pad, frag, proto, 32'($urandom), dst,
                              0, -(payload + $urandom_range(1, ihl * 4)), 0, fb);
                5: build_ipv4(ihl, IpVersion4, payload, pad, frag, proto, 32'($urandom), dst,
                              0, 0, $urandom_range(1, 19), fb);
                6: build_ipv4(15, IpVersion4, payload, pad, frag, proto, 32'($urandom), dst,
                              0, 0, $urandom_range(20, 59), fb);
                default: begin
                    pkt_bytes.delete();
                    repeat ($urandom_range(1, 48)) pkt_bytes.push_back(8'($urandom));
                    queue_packet(fb);
                end
            endcase
        end
    endtask

    task automatic queue_random_packets(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget) queue_random_packet();
    endtask

    // Directed cases, run with the home address and a /24 mask.
    task automatic queue_directed_packets();
        build_ipv4(5, IpVersion4, 8, 0, 16'h0000, ProtoIcmp, RemoteHost, HomeAddr, 0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 0, 0, FlagDontFrag, ProtoTcp, RemoteHost, HomeAddr,
                   0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 12, 0, 16'h0000, ProtoUdp, RemoteHost, HomeAddr, 0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 16, 0, 16'h0000, 8'hFF, RemoteHost, HomeAddr, 0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 16, 0, 16'h0000, 8'h00, RemoteHost, RemoteHost, 0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 10, 0, 16'h0000, 8'h2F, RemoteHost, HomeBcast, 0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 10, 0, 16'h0000, 8'h2F, RemoteHost, LimitedBcast,
                   0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 10, 0, 16'h0000, 8'h2F, RemoteHost, HomeAddr, 0, 0, 0, 1);
        build_ipv4(5, IpVersion4, 8, 0, FlagMoreFrags, ProtoUdp, RemoteHost, HomeAddr,
                   0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 8, 0, 16'h1FFF, ProtoUdp, RemoteHost, HomeAddr, 0, 0, 0, 1);
        build_ipv4(5, IpVersion4, 8, 0, 16'h0001, ProtoTcp, RemoteHost, RemoteHost,
                   0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 8, 0, 16'h0000, ProtoIcmp, RemoteHost, HomeAddr, 1, 0, 0, 0);
        build_ipv4(5, 4'd6, 8, 0, 16'h0000, ProtoIcmp, RemoteHost, HomeAddr, 0, 0, 0, 0);
        build_ipv4(4, IpVersion4, 8, 0, 16'h0000, ProtoIcmp, RemoteHost, HomeAddr, 0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 8, 0, 16'h0000, ProtoIcmp, RemoteHost, HomeAddr, 0, 0, 1, 0);
        build_ipv4(5, IpVersion4, 8, 0, 16'h0000, ProtoIcmp, RemoteHost, HomeAddr, 0, 0, 19, 0);
        // Longest header with options; the kept length reaches its maximum.
        build_ipv4(15, IpVersion4, 20, 0, 16'h0000, 8'h63, RemoteHost, HomeAddr, 0, 0, 0, 0);
        build_ipv4(15, IpVersion4, 20, 0, 16'h0000, ProtoTcp, RemoteHost, HomeAddr,
                   0, 0, 40, 0);
        build_ipv4(5, IpVersion4, 8, 2, 16'h0000, ProtoUdp, RemoteHost, HomeAddr, 0, 10, 0, 0);
        build_ipv4(6, IpVersion4, 8, 0, 16'h0000, ProtoUdp, RemoteHost, HomeAddr, 0, -9, 0, 0);
        // Trailing padding, with all-zero and all-ones address extremes.
        build_ipv4(5, IpVersion4, 4, 6, 16'h0000, ProtoTcp, 32'hFFFF_FFFF, 32'h0000_0000,
                   0, 0, 0, 0);
        build_ipv4(5, IpVersion4, 3, 0, 16'h0000, 8'h84, 32'h0000_0000, HomeAddr, 0, 0, 0, 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_IFACE_ADDRESS: cfg_addr = value;
            CFG_SUBNET_MASK: cfg_mask = value;
            default: cfg_protocols = value[2:0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] addr, input logic [31:0] mask,
                              input logic [2:0] protos);
        write_reg(CFG_IFACE_ADDRESS, addr);
        write_reg(CFG_SUBNET_MASK, mask);
        write_reg(CFG_PROTOCOLS, {29'd0, protos});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every word is sent and every verdict is back, then lets the block settle.
    task automatic finish_phase();
        while (rx_words.size() != 0 || s_valid || pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (rx_words.size() != 0) begin
                next_word = rx_words.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= next_word.data_byte;
                s_last_byte <= next_word.last_byte;
                s_frame_broadcast <= next_word.frame_bcast;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 31);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Input monitor: every accepted word goes through the verdict prediction.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            parse_rx_byte(s_data_byte, s_last_byte, s_frame_broadcast);
            bytes_accepted++;
        end
    end

    // Receiver: the stall pattern switches between three modes, picked at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(100, 600);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN: m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
                    end
                end
            endcase
        end
    end

    // Output monitor: compare each verdict word with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            verdict_hits[m_verdict]++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict word with nothing expected, actual verdict %0h",
                         $time, m_verdict);
                error_count++;
            end else begin
                head_verdict = pending_verdicts.pop_front();
                check_field("verdict", head_verdict.verdict, m_verdict);
                check_field("header_bytes", head_verdict.header_bytes, m_header_bytes);
                check_field("protocol", head_verdict.protocol, m_protocol);
                check_field("source_address", head_verdict.source, m_source_address);
                check_field("dest_address", head_verdict.dest, m_dest_address);
                check_field("pad_bytes", head_verdict.pad_bytes, m_pad_bytes);
                check_field("icmp_reply", head_verdict.reply, m_icmp_reply);
                check_field("icmp_keep_bytes", head_verdict.keep_bytes, m_icmp_keep_bytes);
            end
            verdicts_checked++;
        end
    end

    // Main sequence: reset, then one configuration phase after another.
    initial begin
        int kinds;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0: ;
                1: begin
                    set_config(HomeAddr, HomeMask, 3'b111);
                    queue_directed_packets();
                end
                2: set_config(32'($urandom), 32'hFFFF_FFFF << $urandom_range(0, 31),
                              3'($urandom_range(0, 7)));
                3: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b000);
                4: set_config(32'h0A00_0001, 32'h0000_0000, 3'b101);
                default: set_config(32'($urandom), 32'($urandom), 3'($urandom_range(0, 7)));
            endcase
            queue_random_packets(RandomBytesPerPhase);
            finish_phase();
        end
        kinds = 0;
        for (int v = 0; v < 16; v++) if (verdict_hits[v] != 0) kinds++;
        $display("Checked %0d verdicts over %0d accepted bytes in %0d configuration phases.",
                 verdicts_checked, bytes_accepted, PhaseCount);
        $display("Distinct verdict kinds seen: %0d.", kinds);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog in case the block hangs.
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
